[rtl/core/ceq_pkg.sv]
// Shared types, kind codes and control structs of the coalescing event queue.
package ceq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_ENV    = 3'd1;
    localparam logic [2:0] KIND_MOTION = 3'd2;
    localparam logic [2:0] KIND_LAYER  = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;
    localparam logic [2:0] KIND_GFX    = 3'd5;
    localparam logic [2:0] KIND_RESYNC = 3'd6;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] payload;
        logic [31:0] dy;
        logic [31:0] dx;
        logic [15:0] layer;
        logic [7:0]  pointer;
        logic [15:0] host;
        logic [2:0]  kind;
    } slot_t;

    typedef struct packed {
        logic load;
        logic init_env;
        logic init_mot;
        logic rd_scan;
        logic rd_head;
        logic step_fwd;
        logic step_back;
        logic merge_wr;
        logic resync_wr;
        logic append_wr;
        logic res_wr;
        logic res_ok;
        logic res_poll;
    } cmd_t;

    typedef struct packed {
        logic       op_poll;
        logic [2:0] kind;
        logic       cnt_zero;
        logic       match_env;
        logic       match_mot;
        logic       rd_motion;
        logic       full;
        logic       empty;
        logic       out_free;
    } sts_t;

endpackage

[rtl/core/coalescing_event_queue.sv]
// Top level of the coalescing event queue: controller plus datapath.
//
//  channel | direction | words
//  s_*     | in        | one push or poll request
//  m_*     | out       | one status/event word per request
//
// A poll goes from dispatch to the result state and then waits for the output. When a full
// queue collapses to a resync word, a layer, close or gfx word still follows it. The
// coalescing scan reads one slot at a time through the single read port of the slot memory.
// Reset empties the queue at once; no clearing pass. A request is taken only while the
// controller is idle; a stalled m_tready holds the finished word and the controller waits
// before writing the next one.
module coalescing_event_queue
    import ceq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ev_kind, host_id, pointer_num, layer_id, delta_x, delta_y, payload; zero filled
    input  logic [143:0] s_tdata,
    // op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_kind, out_host, out_pointer, out_layer, out_dx, out_dy, out_payload,
    // out_sequence; zero filled
    output logic [175:0] m_tdata,
    // ok
    output logic         m_tuser
);

    cmd_t         cmd;
    sts_t         sts;
    logic [170:0] res_item;
    logic         in_valid;

    assign in_valid = s_tvalid;

    ceq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ceq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_tuser),
        .in_item   (s_tdata[138:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (m_tuser),
        .out_item  (res_item)
    );

    assign m_tdata = {5'd0, res_item};

endmodule

[rtl/core/ceq_ctrl.sv]
// Controller state machine that sequences pushes, scans and polls.
module ceq_ctrl
    import ceq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISP     = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK = 3'd3;
    localparam logic [2:0] ST_PLACE    = 3'd4;
    localparam logic [2:0] ST_APPEND   = 3'd5;
    localparam logic [2:0] ST_RESULT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ok_reg, ok_next;
    logic       poll_reg, poll_next;
    logic       keep_kind;

    assign in_ready  = (state_reg == ST_IDLE);
    assign keep_kind = (sts.kind == KIND_LAYER) || (sts.kind == KIND_CLOSE) ||
                       (sts.kind == KIND_GFX);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        poll_next  = poll_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                poll_next = 1'b0;
                ok_next   = 1'b0;
                if (sts.op_poll)
                begin
                    if (!sts.empty)
                    begin
                        cmd.rd_head = 1'b1;
                        poll_next   = 1'b1;
                        ok_next     = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
                else if (sts.kind == KIND_NONE)
                begin
                    state_next = ST_RESULT;
                end
                else if (sts.kind == KIND_ENV)
                begin
                    cmd.init_env = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
                else if (sts.kind == KIND_MOTION)
                begin
                    cmd.init_mot = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (sts.kind == KIND_ENV)
                begin
                    if (sts.match_env)
                    begin
                        cmd.merge_wr = 1'b1;
                        ok_next      = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        cmd.step_fwd = 1'b1;
                        state_next   = ST_SCAN_RD;
                    end
                end
                else if (!sts.rd_motion)
                begin
                    state_next = ST_PLACE;
                end
                else if (sts.match_mot)
                begin
                    cmd.merge_wr = 1'b1;
                    ok_next      = 1'b1;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    cmd.step_back = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_PLACE:
            begin
                if (sts.full)
                begin
                    cmd.resync_wr = 1'b1;
                    state_next    = keep_kind ? ST_APPEND : ST_RESULT;
                end
                else
                begin
                    cmd.append_wr = 1'b1;
                    ok_next       = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_APPEND:
            begin
                cmd.append_wr = 1'b1;
                ok_next       = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_ok   = ok_reg;
                    cmd.res_poll = poll_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
            poll_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            poll_reg  <= poll_next;
        end
    end

endmodule

[rtl/core/ceq_dp.sv]
// Datapath: slot memory, ring pointers, scan pointer, sequence counter and result register.
module ceq_dp
    import ceq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_op,
    input  logic [138:0] in_item,
    input  cmd_t         cmd,
    output sts_t         sts,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_ok,
    output logic [170:0] out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    slot_t mem [DEPTH];

    slot_t           item_reg;
    logic            op_reg;
    slot_t           rd_reg;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [31:0]     seq_reg, seq_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            valid_reg, valid_next;
    logic            ok_reg;
    slot_t           res_reg;

    logic [SW-1:0]   tail_sum;
    logic [AW-1:0]   tail;
    logic [AW-1:0]   tail_prev;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    slot_t           wr_data;
    logic [AW-1:0]   rd_addr;

    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(fill_reg);
        if (tail_sum >= SW'(DEPTH))
            tail = AW'(tail_sum - SW'(DEPTH));
        else
            tail = AW'(tail_sum);
        tail_prev = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
    end

    assign sts.op_poll   = (op_reg == OP_POLL);
    assign sts.kind      = item_reg.kind;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.match_env = (rd_reg.kind == KIND_ENV) && (rd_reg.host == item_reg.host);
    assign sts.match_mot = (rd_reg.host == item_reg.host) &&
                           (rd_reg.pointer == item_reg.pointer) &&
                           (rd_reg.layer == item_reg.layer);
    assign sts.rd_motion = (rd_reg.kind == KIND_MOTION);
    assign sts.full      = (fill_reg == CW'(DEPTH));
    assign sts.empty     = (fill_reg == '0);
    assign sts.out_free  = !valid_reg || out_ready;

    // Memory write selection: merge in place, resync at slot 0, or append at the tail.
    always_comb
    begin
        wr_en   = cmd.merge_wr || cmd.resync_wr || cmd.append_wr;
        wr_addr = tail;
        wr_data = item_reg;
        wr_data.seq = seq_reg;
        if (cmd.merge_wr)
        begin
            wr_addr     = ptr_reg;
            wr_data.seq = rd_reg.seq;
            if (item_reg.kind == KIND_MOTION)
            begin
                wr_data.dx = item_reg.dx + rd_reg.dx;
                wr_data.dy = item_reg.dy + rd_reg.dy;
            end
        end
        else if (cmd.resync_wr)
        begin
            wr_addr = '0;
            wr_data = '0;
            wr_data.kind = KIND_RESYNC;
            wr_data.host = item_reg.host;
            wr_data.seq  = seq_reg;
        end
        rd_addr = cmd.rd_head ? head_reg : ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_scan || cmd.rd_head)
            rd_reg <= mem[rd_addr];
        if (cmd.load)
        begin
            op_reg   <= in_op;
            item_reg <= {32'd0, in_item};
        end
        if (cmd.res_wr)
        begin
            ok_reg  <= cmd.res_ok;
            res_reg <= cmd.res_poll ? rd_reg : '0;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        seq_next   = seq_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (cmd.init_env)
        begin
            ptr_next = head_reg;
            cnt_next = fill_reg;
        end
        if (cmd.init_mot)
        begin
            ptr_next = tail_prev;
            cnt_next = fill_reg;
        end
        if (cmd.step_fwd)
        begin
            ptr_next = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.step_back)
        begin
            ptr_next = (ptr_reg == '0) ? AW'(DEPTH - 1) : ptr_reg - AW'(1);
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.resync_wr)
        begin
            head_next = '0;
            fill_next = CW'(1);
            seq_next  = seq_reg + 32'd1;
        end
        if (cmd.append_wr)
        begin
            fill_next = fill_reg + CW'(1);
            seq_next  = seq_reg + 32'd1;
        end
        if (cmd.res_wr && cmd.res_poll)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            fill_next = fill_reg - CW'(1);
        end
        if (cmd.res_wr)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            fill_reg  <= '0;
            seq_reg   <= 32'd1;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            seq_reg   <= seq_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ok    = ok_reg;
    assign out_item  = res_reg;

endmodule

[dv/testbench.sv]
// Self-checking testbench of the coalescing event queue with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
    import ceq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic  op;
        slot_t ev;
    } request_t;

    typedef struct {
        logic  ok;
        slot_t ev;
    } reply_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic         m_tuser;

    request_t    requests[$];
    reply_t      replies[$];
    int          mismatches = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          idle_cycles = 0;
    bit          burst_tx = 1'b0;
    bit          burst_rx = 1'b0;

    // Shadow copy of the queue.
    slot_t       shadow[QDEPTH];
    int unsigned shadow_head = 0;
    int unsigned shadow_fill = 0;
    logic [31:0] shadow_seq = 32'd1;

    coalescing_event_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic logic apply_push(input slot_t e);
        int unsigned s;
        slot_t       w;
        if (e.kind == KIND_NONE)
            return 1'b0;
        if (e.kind == KIND_ENV) begin
            for (int i = 0; i < shadow_fill; i++) begin
                s = (shadow_head + i) % QDEPTH;
                if (shadow[s].kind == KIND_ENV && shadow[s].host == e.host) begin
                    w = e;
                    w.seq = shadow[s].seq;
                    shadow[s] = w;
                    return 1'b1;
                end
            end
        end
        if (e.kind == KIND_MOTION) begin
            for (int i = shadow_fill; i > 0; i--) begin
                s = (shadow_head + i - 1) % QDEPTH;
                if (shadow[s].kind != KIND_MOTION)
                    break;
                if (shadow[s].host == e.host && shadow[s].pointer == e.pointer &&
                    shadow[s].layer == e.layer) begin
                    w = e;
                    w.dx = e.dx + shadow[s].dx;
                    w.dy = e.dy + shadow[s].dy;
                    w.seq = shadow[s].seq;
                    shadow[s] = w;
                    return 1'b1;
                end
            end
        end
        if (shadow_fill >= QDEPTH) begin
            shadow_head = 0;
            shadow_fill = 1;
            w = '0;
            w.kind = KIND_RESYNC;
            w.host = e.host;
            w.seq = shadow_seq;
            shadow[0] = w;
            shadow_seq = shadow_seq + 32'd1;
            if (!(e.kind == KIND_LAYER || e.kind == KIND_CLOSE || e.kind == KIND_GFX))
                return 1'b0;
        end
        w = e;
        w.seq = shadow_seq;
        shadow[(shadow_head + shadow_fill) % QDEPTH] = w;
        shadow_seq = shadow_seq + 32'd1;
        shadow_fill++;
        return 1'b1;
    endfunction

    function automatic reply_t queue_response(input request_t r);
        reply_t y;
        y.ok = 1'b0;
        y.ev = '0;
        if (r.op == OP_PUSH) begin
            y.ok = apply_push(r.ev);
        end
        else if (shadow_fill != 0) begin
            y.ok = 1'b1;
            y.ev = shadow[shadow_head];
            shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_fill--;
        end
        return y;
    endfunction

    function automatic void add_request(input logic op, input logic [2:0] kind,
                                        input bit pooled);
        request_t r;
        logic [15:0] hosts[3] = '{16'h0000, 16'hFFFF, 16'h5A3C};
        r.op = op;
        r.ev.kind = kind;
        r.ev.seq = '0;
        r.ev.dx = $urandom;
        r.ev.dy = $urandom;
        r.ev.payload = $urandom;
        if (pooled) begin
            r.ev.host = hosts[$urandom_range(0, 2)];
            r.ev.pointer = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r.ev.layer = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else begin
            r.ev.host = 16'($urandom);
            r.ev.pointer = 8'($urandom);
            r.ev.layer = 16'($urandom);
        end
        requests.push_back(r);
    endfunction

    function automatic void add_directed(input logic [2:0] kind, input logic [15:0] host,
                                         input logic [31:0] dx, input logic [31:0] dy);
        request_t r;
        r.op = OP_PUSH;
        r.ev = '0;
        r.ev.kind = kind;
        r.ev.host = host;
        r.ev.pointer = 8'hFF;
        r.ev.layer = 16'hFFFF;
        r.ev.dx = dx;
        r.ev.dy = dy;
        r.ev.payload = 32'hFFFF_FFFF;
        requests.push_back(r);
    endfunction

    // Driver: presents the head of the request queue, with random gaps between words.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && s_tready) begin
            replies.push_back(queue_response(requests.pop_front()));
            gap = burst_tx ? 0 : $urandom_range(0, 5);
            send_gap <= gap;
            if (gap == 0 && requests.size() > 0) begin
                s_tdata <= {5'b0, requests[0].ev.payload, requests[0].ev.dy,
                            requests[0].ev.dx, requests[0].ev.layer,
                            requests[0].ev.pointer, requests[0].ev.host,
                            requests[0].ev.kind};
                s_tuser <= requests[0].op;
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
        else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end
            else if (requests.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, requests[0].ev.payload, requests[0].ev.dy,
                            requests[0].ev.dx, requests[0].ev.layer,
                            requests[0].ev.pointer, requests[0].ev.host,
                            requests[0].ev.kind};
                s_tuser <= requests[0].op;
            end
        end
    end

    // Monitor: checks each returned word against the oldest predicted reply.
    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        reply_t y;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_stall <= 0;
        end
        else if (m_tvalid && m_tready) begin
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: ok=%0b data=%h", m_tuser, m_tdata);
            end
            else begin
                y = replies.pop_front();
                if (m_tuser !== y.ok || m_tdata[2:0] !== y.ev.kind ||
                    m_tdata[18:3] !== y.ev.host || m_tdata[26:19] !== y.ev.pointer ||
                    m_tdata[42:27] !== y.ev.layer || m_tdata[74:43] !== y.ev.dx ||
                    m_tdata[106:75] !== y.ev.dy || m_tdata[138:107] !== y.ev.payload ||
                    m_tdata[170:139] !== y.ev.seq || m_tdata[175:171] !== 5'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0b data=%h, got ok=%0b data=%h",
                                 y.ok, {5'b0, y.ev.seq, y.ev.payload, y.ev.dy, y.ev.dx,
                                 y.ev.layer, y.ev.pointer, y.ev.host, y.ev.kind},
                                 m_tuser, m_tdata);
                end
            end
            stall = burst_rx ? 0 : $urandom_range(0, 5);
            recv_stall <= stall;
            m_tready <= (stall == 0);
        end
        else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_tready <= (recv_stall == 1);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Switches between stretches with and without idling on either side.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            burst_tx <= ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 199) == 0)
            burst_rx <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int len;
        add_directed(KIND_NONE, 16'hFFFF, 32'h0, 32'h0);
        add_request(OP_POLL, KIND_NONE, 1'b0);
        add_directed(KIND_ENV, 16'hFFFF, 32'h1, 32'h2);
        add_directed(KIND_MOTION, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_directed(KIND_MOTION, 16'h0000, 32'h0000_0001, 32'hFFFF_FFFF);
        add_directed(KIND_ENV, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_directed(KIND_MOTION, 16'h0001, 32'h0, 32'h0);
        for (int k = 3; k <= 7; k++)
            add_directed(k[2:0], 16'h0000, 32'hFFFF_FFFF, 32'h0);
        add_directed(KIND_MOTION, 16'h0000, 32'h5, 32'h5);
        for (int k = 0; k < 10; k++)
            add_request(OP_POLL, KIND_NONE, 1'b0);
        while (requests.size() < 2000) begin
            phase = $urandom_range(0, 9);
            if (phase <= 4) begin
                len = $urandom_range(1, 40);
                for (int k = 0; k < len; k++)
                    add_request(OP_PUSH, 3'($urandom_range(1, 7)), 1'b1);
            end
            else if (phase <= 6) begin
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                    add_request(OP_POLL, 3'($urandom), 1'b0);
            end
            else if (phase == 7) begin
                // Push a long run near or past capacity so the queue may collapse to a resync event.
                len = $urandom_range(60, 75);
                for (int k = 0; k < len; k++)
                    add_request(OP_PUSH, 3'($urandom_range(3, 7)), 1'b0);
            end
            else begin
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                    add_request(1'($urandom_range(0, 1)), 3'($urandom),
                                1'($urandom_range(0, 1)));
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (requests.size() != 0 || replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/ceq_pkg.sv
rtl/core/ceq_ctrl.sv
rtl/core/ceq_dp.sv
rtl/core/coalescing_event_queue.sv
dv/testbench.sv
